// ===== sv/rdr_pkg.sv =====
package rdr_pkg;

   localparam int RING_DEPTH_DEF   = 1024;
   localparam int REPORT_BYTES_DEF = 64;

   // request commands
   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;

   // reply report bytes
   localparam logic [7:0] REPLY_ID       = 8'h05;
   localparam logic [7:0] REPLY_SUB      = 8'h01;
   localparam logic [7:0] REPLY_ACK      = 8'hBB;
   localparam logic [7:0] REPLY_NACK     = 8'hAA;
   localparam logic [7:0] REPLY_ACK_END  = 8'hBF;
   localparam logic [7:0] REPLY_NACK_END = 8'hAE;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] wdata;
   } ring_op_type;

endpackage

// ===== sv/rdr_report_ram.sv =====
module rdr_report_ram #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rdr_ring.sv =====
module rdr_ring #(
   parameter int RING_DEPTH = rdr_pkg::RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rdr_pkg::ring_op_type op,
   output logic                 empty,
   output logic [7:0]           rdata
);

   import rdr_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

   logic [7:0]       mem [RING_DEPTH];
   logic [7:0]       rdata_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic             full_hit;
   logic             do_write;

   assign wr_next  = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next  = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign full_hit = (wr_next == rd_ptr_ff);
   assign do_write = op.push && !full_hit;
   assign empty    = (rd_ptr_ff == wr_ptr_ff);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (op.clear || (op.push && full_hit)) begin
         // clear, or ring full: drop the byte and restart both pointers
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end else begin
         if (op.push) begin
            wr_ptr_in = wr_next;
         end
         if (op.pop) begin
            rd_ptr_in = rd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= op.wdata;
      end
      if (op.pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/hid_report_deframer_ring_unit.sv =====
// Report deframer with byte ring. Report bytes (req_cmd 0) are taken one per
// cycle while the block is idle and stored in a small report memory; the last
// byte of each report is the XOR check of all bytes before it. On a good check
// the payload (length from byte 1, clamped to three less than the report size)
// is copied from the report memory into the ring memory one byte a cycle, so
// the final byte of a good report holds req_stall high while the copy runs,
// before the block takes the next beat. When csr_data has set the reply
// enable, each finished report then emits a full ack or nack reply report on
// the rsp channel, one byte per cycle as rsp_stall allows. A pop (req_cmd 1)
// holds req_stall through ST_POP and, when the ring has data, ST_POP_DATA,
// because the ring memory read is registered; a pending response beat
// stretches that. It returns one data beat or an empty beat. Clear (req_cmd 2)
// zeroes the ring pointers, and code 3 is ignored.
// A push into a full ring drops that byte and restarts both pointers at zero.
// csr_ready is always high; write the register only while the block is idle.
module hid_report_deframer_ring_unit #(
   parameter int RING_DEPTH   = rdr_pkg::RING_DEPTH_DEF,
   parameter int REPORT_BYTES = rdr_pkg::REPORT_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_byte_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_last,
   // control register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   import rdr_pkg::*;

   localparam int POS_W = $clog2(REPORT_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_BYTES - 1);
   localparam logic [POS_W-1:0] MAX_LEN  = POS_W'(REPORT_BYTES - 3);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY,
      ST_REPLY,
      ST_POP,
      ST_POP_DATA
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [POS_W-1:0] len_ff, len_in;
   logic             good_ff, good_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic             push_v_ff, push_v_in;
   logic             reply_en_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             out_free;
   logic             out_load;
   logic             rep_wr_en;
   logic             rep_rd_en;
   logic [POS_W-1:0] rep_rd_addr;
   logic [7:0]       rep_rd_data;
   logic [7:0]       reply_byte;
   ring_op_type      ring_op;
   logic             ring_empty;
   logic [7:0]       ring_rdata;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   // the response slot can take a new beat this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rep_wr_en   = req_accept && (req_cmd == CMD_BYTE);
   assign rep_rd_en   = (state_ff == ST_COPY) && (cnt_ff != len_ff);
   assign rep_rd_addr = cnt_ff + POS_W'(2);

   rdr_report_ram #(
      .DEPTH(REPORT_BYTES)
   ) u_report_ram (
      .clock  (clock),
      .wr_en  (rep_wr_en),
      .wr_addr(pos_ff),
      .wr_data(req_byte_in),
      .rd_en  (rep_rd_en),
      .rd_addr(rep_rd_addr),
      .rd_data(rep_rd_data)
   );

   rdr_ring #(
      .RING_DEPTH(RING_DEPTH)
   ) u_ring (
      .clock(clock),
      .reset(reset),
      .op   (ring_op),
      .empty(ring_empty),
      .rdata(ring_rdata)
   );

   // reply report contents by byte index
   always_comb begin
      if (cnt_ff == POS_W'(0)) begin
         reply_byte = REPLY_ID;
      end else if (cnt_ff == POS_W'(1)) begin
         reply_byte = REPLY_SUB;
      end else if (cnt_ff == POS_W'(2)) begin
         reply_byte = good_ff ? REPLY_ACK : REPLY_NACK;
      end else if (cnt_ff == LAST_POS) begin
         reply_byte = good_ff ? REPLY_ACK_END : REPLY_NACK_END;
      end else begin
         reply_byte = 8'h00;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      len_in      = len_ff;
      good_in     = good_ff;
      cnt_in      = cnt_ff;
      push_v_in   = 1'b0;
      out_load    = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;

      ring_op       = '0;
      ring_op.push  = push_v_ff;
      ring_op.wdata = rep_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  CMD_BYTE: begin
                     if (pos_ff == LAST_POS) begin
                        // check byte: close the report
                        good_in = (req_byte_in == xor_ff);
                        pos_in  = '0;
                        xor_in  = '0;
                        cnt_in  = '0;
                        if (req_byte_in == xor_ff) begin
                           state_in = ST_COPY;
                        end else if (reply_en_ff) begin
                           state_in = ST_REPLY;
                        end
                     end else begin
                        xor_in = xor_ff ^ req_byte_in;
                        pos_in = pos_ff + POS_W'(1);
                        if (pos_ff == POS_W'(1)) begin
                           // clamp the length byte
                           len_in = (req_byte_in > 8'(REPORT_BYTES - 3)) ?
                                    MAX_LEN : req_byte_in[POS_W-1:0];
                        end
                     end
                  end
                  CMD_POP: begin
                     state_in = ST_POP;
                  end
                  CMD_CLEAR: begin
                     ring_op.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            // read one payload byte a cycle, push it the cycle after
            if (rep_rd_en) begin
               push_v_in = 1'b1;
               cnt_in    = cnt_ff + POS_W'(1);
            end else if (!push_v_ff) begin
               cnt_in   = '0;
               state_in = reply_en_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_kind_in = KIND_REPLY;
               rsp_byte_in = reply_byte;
               rsp_last_in = (cnt_ff == LAST_POS);
               cnt_in      = cnt_ff + POS_W'(1);
               if (cnt_ff == LAST_POS) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               if (ring_empty) begin
                  out_load    = 1'b1;
                  rsp_kind_in = KIND_EMPTY;
                  rsp_byte_in = 8'h00;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  // slot is free now, so it stays free for the data beat
                  ring_op.pop = 1'b1;
                  state_in    = ST_POP_DATA;
               end
            end
         end
         ST_POP_DATA: begin
            out_load    = 1'b1;
            rsp_kind_in = KIND_DATA;
            rsp_byte_in = ring_rdata;
            rsp_last_in = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         xor_ff       <= '0;
         cnt_ff       <= '0;
         push_v_ff    <= 1'b0;
         reply_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         cnt_ff       <= cnt_in;
         push_v_ff    <= push_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            reply_en_ff <= csr_data;
         end
      end
      len_ff      <= len_in;
      good_ff     <= good_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // pushes only come from the copy sequence
   a_push_in_copy: assert property (@(posedge clock) disable iff (reset)
      push_v_ff |-> (state_ff == ST_COPY))
      else $error("ring push outside copy");

   // the data beat of a pop always finds the response slot empty
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_DATA) |-> !rsp_valid_ff)
      else $error("pop data would overwrite a pending beat");

   // the copy never reads past the clamped length
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (cnt_ff <= len_ff && len_ff <= MAX_LEN))
      else $error("copy counter out of range");

   // the final reply beat returns the sequencer to idle
   a_reply_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && out_free && cnt_ff == LAST_POS) |=>
      (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("reply did not end cleanly");

endmodule
